FILE: rtl/assert_macros.svh
// Assertion helpers for the cache lookup RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, held off while in reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/l1vl2_pkg.sv
package l1vl2_pkg;

    localparam int LINE_OFFSET_BITS_DEF = 6;
    localparam int L1_SET_BITS_DEF      = 7;
    localparam int L1_WAYS_DEF          = 4;
    localparam int VICTIM_ENTRIES_DEF   = 8;
    localparam int L2_SET_BITS_DEF      = 10;
    localparam int L2_WAYS_DEF          = 8;

    localparam int ADDR_W  = 32;
    localparam int STAMP_W = 32;
    localparam int LAT_W   = 10;
    localparam int LVL_W   = 2;
    localparam int CFG_W   = 10;
    localparam int CFG_IDX_W = 3;

    localparam logic [7:0]       L1_HIT_LAT_RST     = 8'd1;
    localparam logic [7:0]       VICTIM_HIT_LAT_RST = 8'd1;
    localparam logic [7:0]       L2_HIT_LAT_RST     = 8'd10;
    localparam logic [7:0]       L1_L2_XFER_RST     = 8'd5;
    localparam logic [LAT_W-1:0] MEM_LAT_RST        = 10'd350;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_L1_HIT_LAT     = 3'd0,
        CFG_VICTIM_HIT_LAT = 3'd1,
        CFG_L2_HIT_LAT     = 3'd2,
        CFG_L1_L2_XFER     = 3'd3,
        CFG_MEM_LAT        = 3'd4
    } cfg_idx_t;

    typedef enum logic [LVL_W-1:0] {
        LVL_L1     = 2'd0,
        LVL_VICTIM = 2'd1,
        LVL_L2     = 2'd2,
        LVL_MEM    = 2'd3
    } hit_lvl_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_PICK,
        ST_WR
    } state_t;

endpackage

FILE: rtl/l1vl2_ram.sv
module l1vl2_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/l1_victim_l2_cache_lookup.sv
// Channel | Direction | Handshake           | Payload
// request | in        | in_valid/in_ready   | address, access_time
// result  | out       | out_valid/out_ready | latency, hit_level
// config  | in        | cfg_we              | cfg_index, cfg_data
//
// A request passes through accept with the set reads issued, registering the
// rows of both set memories, resolving hits and LRU ways, then write-back and
// loading the result register, in a single read-modify-write pass over the L1
// and L2 set memories. After reset a clearing pass writes every row of both
// memories before the first request is taken. A stalled result holds the
// block in write-back.
`include "assert_macros.svh"

module l1_victim_l2_cache_lookup #(
    parameter int LINE_OFFSET_BITS = l1vl2_pkg::LINE_OFFSET_BITS_DEF,
    parameter int L1_SET_BITS      = l1vl2_pkg::L1_SET_BITS_DEF,
    parameter int L1_WAYS          = l1vl2_pkg::L1_WAYS_DEF,
    parameter int VICTIM_ENTRIES   = l1vl2_pkg::VICTIM_ENTRIES_DEF,
    parameter int L2_SET_BITS      = l1vl2_pkg::L2_SET_BITS_DEF,
    parameter int L2_WAYS          = l1vl2_pkg::L2_WAYS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [l1vl2_pkg::ADDR_W-1:0]   address,
    input  logic [l1vl2_pkg::STAMP_W-1:0]  access_time,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [l1vl2_pkg::LAT_W-1:0]    latency,
    output logic [l1vl2_pkg::LVL_W-1:0]    hit_level,
    input  logic                           cfg_we,
    input  logic [l1vl2_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [l1vl2_pkg::CFG_W-1:0]    cfg_data
);
    import l1vl2_pkg::*;

    localparam int LINE_W  = ADDR_W - LINE_OFFSET_BITS;
    localparam int T1W     = LINE_W - L1_SET_BITS;
    localparam int T2W     = LINE_W - L2_SET_BITS;
    localparam int E1W     = 1 + T1W + STAMP_W;
    localparam int E2W     = 1 + T2W + STAMP_W;
    localparam int R1W     = L1_WAYS * E1W;
    localparam int R2W     = L2_WAYS * E2W;
    localparam int L1_ROWS = 1 << L1_SET_BITS;
    localparam int L2_ROWS = 1 << L2_SET_BITS;
    localparam int L1AW    = (L1_SET_BITS > 0) ? L1_SET_BITS : 1;
    localparam int L2AW    = (L2_SET_BITS > 0) ? L2_SET_BITS : 1;
    localparam int RAM1_D  = (L1_ROWS > 1) ? L1_ROWS : 2;
    localparam int RAM2_D  = (L2_ROWS > 1) ? L2_ROWS : 2;
    localparam int CLR_AW  = (L1AW > L2AW) ? L1AW : L2AW;
    localparam int CLR_N   = (RAM1_D > RAM2_D) ? RAM1_D : RAM2_D;
    localparam int W1W     = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;
    localparam int W2W     = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
    localparam int VW      = (VICTIM_ENTRIES > 1) ? $clog2(VICTIM_ENTRIES) : 1;
    localparam logic [L1AW-1:0] L1_MASK = L1AW'(L1_ROWS - 1);
    localparam logic [L2AW-1:0] L2_MASK = L2AW'(L2_ROWS - 1);

    // configuration registers
    logic [7:0]       l1_lat_reg, vic_lat_reg, l2_lat_reg, xfer_reg;
    logic [LAT_W-1:0] mem_lat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_lat_reg  <= L1_HIT_LAT_RST;
            vic_lat_reg <= VICTIM_HIT_LAT_RST;
            l2_lat_reg  <= L2_HIT_LAT_RST;
            xfer_reg    <= L1_L2_XFER_RST;
            mem_lat_reg <= MEM_LAT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_L1_HIT_LAT:     l1_lat_reg  <= cfg_data[7:0];
                CFG_VICTIM_HIT_LAT: vic_lat_reg <= cfg_data[7:0];
                CFG_L2_HIT_LAT:     l2_lat_reg  <= cfg_data[7:0];
                CFG_L1_L2_XFER:     xfer_reg    <= cfg_data[7:0];
                CFG_MEM_LAT:        mem_lat_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // control state
    state_t state_reg, state_next;
    logic [CLR_AW-1:0] clr_reg;
    logic              out_valid_reg;
    logic [LAT_W-1:0]  latency_reg;
    logic [LVL_W-1:0]  hit_level_reg;
    logic              in_acc, out_load;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_load  = (state_reg == ST_WR) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign latency   = latency_reg;
    assign hit_level = hit_level_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == CLR_AW'(CLR_N - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (in_acc) state_next = ST_LOOK;
            ST_LOOK:  state_next = ST_PICK;
            ST_PICK:  state_next = ST_WR;
            ST_WR:    if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    // request latch
    logic [ADDR_W-1:0]  addr_reg;
    logic [STAMP_W-1:0] now_reg;
    logic [LINE_W-1:0]  line;
    logic [L1AW-1:0]    s1, rd_s1;
    logic [L2AW-1:0]    s2, rd_s2;
    logic [T1W-1:0]     t1;
    logic [T2W-1:0]     t2;

    assign line  = addr_reg[ADDR_W-1:LINE_OFFSET_BITS];
    assign s1    = line[L1AW-1:0] & L1_MASK;
    assign s2    = line[L2AW-1:0] & L2_MASK;
    assign t1    = line[LINE_W-1:L1_SET_BITS];
    assign t2    = line[LINE_W-1:L2_SET_BITS];
    assign rd_s1 = address[LINE_OFFSET_BITS +: L1AW] & L1_MASK;
    assign rd_s2 = address[LINE_OFFSET_BITS +: L2AW] & L2_MASK;

    // set memories: one row holds {valid, tag, stamp} of every way
    logic           ram1_we, ram2_we;
    logic [L1AW-1:0] ram1_wa;
    logic [L2AW-1:0] ram2_wa;
    logic [R1W-1:0] ram1_wd, ram1_rd, row1_reg, new_row1;
    logic [R2W-1:0] ram2_wd, ram2_rd, row2_reg, new_row2;
    logic           l1_hit_reg, v_hit_reg, l2_hit_reg;

    assign ram1_we = (state_reg == ST_CLEAR) || out_load;
    assign ram2_we = (state_reg == ST_CLEAR) || (out_load && !l1_hit_reg && !v_hit_reg);
    assign ram1_wa = (state_reg == ST_CLEAR) ? clr_reg[L1AW-1:0] : s1;
    assign ram2_wa = (state_reg == ST_CLEAR) ? clr_reg[L2AW-1:0] : s2;
    assign ram1_wd = (state_reg == ST_CLEAR) ? '0 : new_row1;
    assign ram2_wd = (state_reg == ST_CLEAR) ? '0 : new_row2;

    l1vl2_ram #(.WIDTH(R1W), .DEPTH(RAM1_D)) u_l1_ram (
        .clk   (clk),
        .we    (ram1_we),
        .waddr ($clog2(RAM1_D)'(ram1_wa)),
        .wdata (ram1_wd),
        .raddr ($clog2(RAM1_D)'(rd_s1)),
        .rdata (ram1_rd)
    );

    l1vl2_ram #(.WIDTH(R2W), .DEPTH(RAM2_D)) u_l2_ram (
        .clk   (clk),
        .we    (ram2_we),
        .waddr ($clog2(RAM2_D)'(ram2_wa)),
        .wdata (ram2_wd),
        .raddr ($clog2(RAM2_D)'(rd_s2)),
        .rdata (ram2_rd)
    );

    // victim cache in flops
    logic [LINE_W-1:0]  vic_line_reg  [VICTIM_ENTRIES];
    logic [STAMP_W-1:0] vic_stamp_reg [VICTIM_ENTRIES];
    logic [VICTIM_ENTRIES-1:0] vic_valid_reg;

    // unpack registered rows
    logic               l1_v [L1_WAYS];
    logic [T1W-1:0]     l1_t [L1_WAYS];
    logic [STAMP_W-1:0] l1_s [L1_WAYS];
    logic               l2_v [L2_WAYS];
    logic [T2W-1:0]     l2_t [L2_WAYS];
    logic [STAMP_W-1:0] l2_s [L2_WAYS];

    always_comb
    begin
        for (int w = 0; w < L1_WAYS; w++)
        begin
            l1_v[w] = row1_reg[w*E1W + E1W - 1];
            l1_t[w] = row1_reg[w*E1W + STAMP_W +: T1W];
            l1_s[w] = row1_reg[w*E1W +: STAMP_W];
        end
        for (int w = 0; w < L2_WAYS; w++)
        begin
            l2_v[w] = row2_reg[w*E2W + E2W - 1];
            l2_t[w] = row2_reg[w*E2W + STAMP_W +: T2W];
            l2_s[w] = row2_reg[w*E2W +: STAMP_W];
        end
    end

    // hits and LRU picks, resolved in the pick cycle
    logic           l1_hit_c, v_hit_c, l2_hit_c;
    logic [W1W-1:0] h1_c, p1_c, h1_reg, p1_reg;
    logic [W2W-1:0] h2_c, p2_c, h2_reg, p2_reg;
    logic [VW-1:0]  hv_c, pv_c, hv_reg, pv_reg;
    logic           f1, f2, fv;

    always_comb
    begin
        l1_hit_c = 1'b0; h1_c = '0;
        for (int w = L1_WAYS - 1; w >= 0; w--)
        begin
            if (l1_v[w] && l1_t[w] == t1)
            begin
                l1_hit_c = 1'b1; h1_c = W1W'(w);
            end
        end
        v_hit_c = 1'b0; hv_c = '0;
        for (int e = VICTIM_ENTRIES - 1; e >= 0; e--)
        begin
            if (vic_valid_reg[e] && vic_line_reg[e] == line)
            begin
                v_hit_c = 1'b1; hv_c = VW'(e);
            end
        end
        l2_hit_c = 1'b0; h2_c = '0;
        for (int w = L2_WAYS - 1; w >= 0; w--)
        begin
            if (l2_v[w] && l2_t[w] == t2)
            begin
                l2_hit_c = 1'b1; h2_c = W2W'(w);
            end
        end
        // first invalid way, else the lowest stamp with ties to the lower way
        f1 = 1'b0; p1_c = '0;
        for (int w = L1_WAYS - 1; w >= 0; w--)
        begin
            if (!l1_v[w])
            begin
                f1 = 1'b1; p1_c = W1W'(w);
            end
        end
        if (!f1)
        begin
            for (int w = 1; w < L1_WAYS; w++)
            begin
                if (l1_s[w] < l1_s[p1_c]) p1_c = W1W'(w);
            end
        end
        fv = 1'b0; pv_c = '0;
        for (int e = VICTIM_ENTRIES - 1; e >= 0; e--)
        begin
            if (!vic_valid_reg[e])
            begin
                fv = 1'b1; pv_c = VW'(e);
            end
        end
        if (!fv)
        begin
            for (int e = 1; e < VICTIM_ENTRIES; e++)
            begin
                if (vic_stamp_reg[e] < vic_stamp_reg[pv_c]) pv_c = VW'(e);
            end
        end
        f2 = 1'b0; p2_c = '0;
        for (int w = L2_WAYS - 1; w >= 0; w--)
        begin
            if (!l2_v[w])
            begin
                f2 = 1'b1; p2_c = W2W'(w);
            end
        end
        if (!f2)
        begin
            for (int w = 1; w < L2_WAYS; w++)
            begin
                if (l2_s[w] < l2_s[p2_c]) p2_c = W2W'(w);
            end
        end
    end

    // write-back rows and result
    logic [LINE_W-1:0] evict_line;
    logic [LAT_W-1:0]  lat_c;
    hit_lvl_t          lvl_c;

    assign evict_line = (LINE_W'(l1_t[p1_reg]) << L1_SET_BITS) | LINE_W'(s1);

    always_comb
    begin
        new_row1 = row1_reg;
        new_row2 = row2_reg;
        if (l1_hit_reg)
        begin
            new_row1[32'(h1_reg)*E1W +: STAMP_W] = now_reg;
            lat_c = LAT_W'(l1_lat_reg);
            lvl_c = LVL_L1;
        end
        else if (v_hit_reg)
        begin
            new_row1[32'(p1_reg)*E1W +: E1W] = {1'b1, t1, now_reg};
            lat_c = LAT_W'(vic_lat_reg);
            lvl_c = LVL_VICTIM;
        end
        else
        begin
            new_row1[32'(p1_reg)*E1W +: E1W] = {1'b1, t1, now_reg};
            if (l2_hit_reg)
            begin
                new_row2[32'(h2_reg)*E2W +: STAMP_W] = now_reg;
                lat_c = LAT_W'(xfer_reg) + LAT_W'(l2_lat_reg);
                lvl_c = LVL_L2;
            end
            else
            begin
                new_row2[32'(p2_reg)*E2W +: E2W] = {1'b1, t2, now_reg};
                lat_c = mem_lat_reg;
                lvl_c = LVL_MEM;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            vic_valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            // swap, drop or insert into the victim cache at write-back
            if (out_load && !l1_hit_reg)
            begin
                if (v_hit_reg)
                begin
                    if (!l1_v[p1_reg]) vic_valid_reg[hv_reg] <= 1'b0;
                end
                else if (l1_v[p1_reg])
                begin
                    vic_valid_reg[pv_reg] <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            addr_reg <= address;
            now_reg  <= access_time;
        end
        if (state_reg == ST_LOOK)
        begin
            row1_reg <= ram1_rd;
            row2_reg <= ram2_rd;
        end
        if (state_reg == ST_PICK)
        begin
            l1_hit_reg <= l1_hit_c;
            v_hit_reg  <= v_hit_c;
            l2_hit_reg <= l2_hit_c;
            h1_reg <= h1_c;
            p1_reg <= p1_c;
            h2_reg <= h2_c;
            p2_reg <= p2_c;
            hv_reg <= hv_c;
            pv_reg <= pv_c;
        end
        if (out_load)
        begin
            latency_reg   <= lat_c;
            hit_level_reg <= lvl_c;
            if (!l1_hit_reg)
            begin
                if (v_hit_reg)
                begin
                    if (l1_v[p1_reg])
                    begin
                        vic_line_reg[hv_reg]  <= evict_line;
                        vic_stamp_reg[hv_reg] <= now_reg;
                    end
                end
                else if (l1_v[p1_reg])
                begin
                    vic_line_reg[pv_reg]  <= evict_line;
                    vic_stamp_reg[pv_reg] <= now_reg;
                end
            end
        end
    end

    `ASSERT_CLK(a_no_accept_in_clear, clk, rst_n, (state_reg == ST_CLEAR) |-> !in_ready, "request taken during clearing pass")
    `ASSERT_CLK(a_result_from_wb, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == ST_WR), "result raised outside write-back")
    `ASSERT_CLK(a_look_after_accept, clk, rst_n, (state_reg == ST_LOOK) |-> $past(in_acc), "lookup without an accepted request")

endmodule

FILE: sim/tb_l1_victim_l2_cache_lookup.sv
`timescale 1ns / 100ps

class cache_result_board;
    logic [9:0] exp_latency[$];
    logic [1:0] exp_level[$];
    int         mismatches;
    int         checked;

    function new();
        mismatches = 0;
        checked = 0;
    endfunction

    function void note_request(logic [9:0] lat, logic [1:0] lvl);
        exp_latency.push_back(lat);
        exp_level.push_back(lvl);
    endfunction

    function void check_result(logic [9:0] lat, logic [1:0] lvl);
        logic [9:0] el;
        logic [1:0] ev;
        if (exp_latency.size() == 0) begin
            $display("%0t: unexpected result latency=%0d level=%0d", $realtime, lat, lvl);
            mismatches++;
            return;
        end
        el = exp_latency.pop_front();
        ev = exp_level.pop_front();
        checked++;
        if (lat !== el) begin
            $display("%0t: latency expected %0d actual %0d", $realtime, el, lat);
            mismatches++;
        end
        if (lvl !== ev) begin
            $display("%0t: hit_level expected %0d actual %0d", $realtime, ev, lvl);
            mismatches++;
        end
    endfunction

    function int pending();
        return exp_latency.size();
    endfunction
endclass

module tb_l1_victim_l2_cache_lookup;
    import l1vl2_pkg::*;

    localparam int OFS = LINE_OFFSET_BITS_DEF;
    localparam int S1B = L1_SET_BITS_DEF;
    localparam int NW1 = L1_WAYS_DEF;
    localparam int NV = VICTIM_ENTRIES_DEF;
    localparam int S2B = L2_SET_BITS_DEF;
    localparam int NW2 = L2_WAYS_DEF;
    localparam int NS1 = 1 << S1B;
    localparam int NS2 = 1 << S2B;
    localparam int TGB = ADDR_W - OFS - S2B;

    logic clk, rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    logic [ADDR_W-1:0] address;
    logic [STAMP_W-1:0] access_time;
    logic [LAT_W-1:0] latency;
    logic [LVL_W-1:0] hit_level;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    l1_victim_l2_cache_lookup dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .address(address), .access_time(access_time),
        .out_valid(out_valid), .out_ready(out_ready),
        .latency(latency), .hit_level(hit_level),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Shadow copy of the three cache levels; L1 and L2 are indexed [set][way].
    logic [31:0] l1_tag[NS1][NW1];
    logic        l1_vld[NS1][NW1];
    logic [31:0] l1_stp[NS1][NW1];
    logic [31:0] vc_line[NV];
    logic        vc_vld[NV];
    logic [31:0] vc_stp[NV];
    logic [31:0] l2_tag[NS2][NW2];
    logic        l2_vld[NS2][NW2];
    logic [31:0] l2_stp[NS2][NW2];

    logic [7:0] lat_l1, lat_vc, lat_l2, lat_xfer;
    logic [9:0] lat_mem;

    cache_result_board board;
    int  sent;
    int  rx_hold;           // cycles the result side stalls outright
    bit  hold_req;          // ask the result side for one long hold-off
    bit  hold_taken;
    bit  quiet;             // no idling on either side
    int  n_level[4];
    bit  done_sending;

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Drop all lines and restore register defaults, as at reset.
    task automatic clear_shadow();
        for (int s = 0; s < NS1; s++)
            for (int w = 0; w < NW1; w++)
                l1_vld[s][w] = 0;
        for (int s = 0; s < NS2; s++)
            for (int w = 0; w < NW2; w++)
                l2_vld[s][w] = 0;
        for (int e = 0; e < NV; e++)
            vc_vld[e] = 0;
        lat_l1 = L1_HIT_LAT_RST;
        lat_vc = VICTIM_HIT_LAT_RST;
        lat_l2 = L2_HIT_LAT_RST;
        lat_xfer = L1_L2_XFER_RST;
        lat_mem = MEM_LAT_RST;
    endtask

    // Victim cache: first free entry, else the oldest stamp (lowest index on ties).
    function automatic int vc_pick();
        int b;
        b = 0;
        for (int i = 0; i < NV; i++)
            if (!vc_vld[i])
                return i;
        for (int i = 1; i < NV; i++)
            if (vc_stp[i] < vc_stp[b])
                b = i;
        return b;
    endfunction

    function automatic int l1_pick(int s);
        int b;
        b = 0;
        for (int i = 0; i < NW1; i++)
            if (!l1_vld[s][i])
                return i;
        for (int i = 1; i < NW1; i++)
            if (l1_stp[s][i] < l1_stp[s][b])
                b = i;
        return b;
    endfunction

    function automatic int l2_pick(int s);
        int b;
        b = 0;
        for (int i = 0; i < NW2; i++)
            if (!l2_vld[s][i])
                return i;
        for (int i = 1; i < NW2; i++)
            if (l2_stp[s][i] < l2_stp[s][b])
                b = i;
        return b;
    endfunction

    // Walk L1, victim, L2 in order, update the shadow and log the expected result.
    task automatic predict_lookup(logic [31:0] addr, logic [31:0] now);
        logic [31:0] ln, t1, t2;
        int s1, s2, w, e, lvl;
        logic [10:0] lat;
        ln = addr >> OFS;
        s1 = ln & (NS1 - 1);
        t1 = ln >> S1B;
        s2 = ln & (NS2 - 1);
        t2 = ln >> S2B;
        for (int i = 0; i < NW1; i++)
            if (l1_vld[s1][i] && l1_tag[s1][i] == t1) begin
                l1_stp[s1][i] = now;
                board.note_request(10'(lat_l1), LVL_L1);
                n_level[LVL_L1]++;
                return;
            end
        for (int i = 0; i < NV; i++)
            if (vc_vld[i] && vc_line[i] == ln) begin
                w = l1_pick(s1);
                if (l1_vld[s1][w]) begin
                    // swap the L1 LRU line into this victim entry
                    vc_line[i] = (l1_tag[s1][w] << S1B) | s1;
                    vc_stp[i] = now;
                end else
                    vc_vld[i] = 0;
                l1_tag[s1][w] = t1;
                l1_vld[s1][w] = 1;
                l1_stp[s1][w] = now;
                board.note_request(10'(lat_vc), LVL_VICTIM);
                n_level[LVL_VICTIM]++;
                return;
            end
        lvl = LVL_MEM;
        for (int i = 0; i < NW2; i++)
            if (l2_vld[s2][i] && l2_tag[s2][i] == t2) begin
                l2_stp[s2][i] = now;
                lvl = LVL_L2;
                break;
            end
        w = l1_pick(s1);
        if (l1_vld[s1][w]) begin
            e = vc_pick();
            vc_line[e] = (l1_tag[s1][w] << S1B) | s1;
            vc_vld[e] = 1;
            vc_stp[e] = now;
        end
        l1_tag[s1][w] = t1;
        l1_vld[s1][w] = 1;
        l1_stp[s1][w] = now;
        if (lvl == LVL_L2)
            lat = 11'(lat_xfer) + 11'(lat_l2);
        else begin
            w = l2_pick(s2);
            l2_tag[s2][w] = t2;
            l2_vld[s2][w] = 1;
            l2_stp[s2][w] = now;
            lat = 11'(lat_mem);
        end
        if (lat > 1023)
            lat = 1023;
        board.note_request(lat[9:0], 2'(lvl));
        n_level[lvl]++;
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [9:0] val);
        @(negedge clk);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 0;
        case (idx)
            CFG_L1_HIT_LAT:     lat_l1 = val[7:0];
            CFG_VICTIM_HIT_LAT: lat_vc = val[7:0];
            CFG_L2_HIT_LAT:     lat_l2 = val[7:0];
            CFG_L1_L2_XFER:     lat_xfer = val[7:0];
            default:            lat_mem = val;
        endcase
    endtask

    // Offer one request; hold it until accepted, then log its prediction.
    task automatic send_request(logic [31:0] addr, logic [31:0] now);
        if (!quiet && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 13)) @(negedge clk);
        address = addr;
        access_time = now;
        in_valid = 1;
        do
            @(posedge clk);
        while (!in_ready);
        predict_lookup(addr, now);
        sent++;
        @(negedge clk);
        in_valid = 0;
    endtask

    task automatic drain();
        while (board.pending() != 0)
            @(posedge clk);
        repeat (10) @(negedge clk);
    endtask

    // Address built from set/tag pieces: a narrow tag pool makes set conflicts and
    // victim traffic common; occasionally any 32-bit address.
    function automatic logic [31:0] pick_address(int pool);
        logic [31:0] a;
        a = $urandom();
        if ($urandom_range(0, 9) == 0)
            return a;
        a[OFS +: S2B] = S2B'($urandom_range(0, 3));
        a[OFS + S2B +: TGB] = TGB'($urandom_range(0, pool));
        return a;
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 0;
            hold_taken <= 0;
        end else if (hold_req && !hold_taken) begin
            out_ready <= 0;
            hold_taken <= 1;
            rx_hold <= 299;
        end else if (rx_hold > 0) begin
            out_ready <= 0;
            rx_hold <= rx_hold - 1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            out_ready <= 0;
            rx_hold <= $urandom_range(0, 12);
        end else
            out_ready <= 1;
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            board.check_result(latency, hit_level);

    initial begin
        logic [31:0] clock_now;
        board = new();
        rst_n = 0;
        in_valid = 0;
        address = 0;
        access_time = 0;
        cfg_we = 0;
        cfg_index = CFG_L1_HIT_LAT;
        cfg_data = 0;
        sent = 0;
        hold_req = 0;
        quiet = 0;
        done_sending = 0;
        clear_shadow();
        repeat (5) @(negedge clk);
        rst_n = 1;

        // Directed: address extremes, stamp extremes, L1 hit, victim hit, L2 hit.
        send_request(32'h0, 32'h0);
        send_request(32'h0, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'h5);
        send_request(32'hFFFF_FFC0, 32'h6);
        // five lines in one L1 set push the first into the victim cache
        for (int i = 1; i <= 5; i++)
            send_request(32'h1000 + (i << (OFS + S1B)), 32'h10 + i);
        send_request(32'h1000 + (1 << (OFS + S1B)), 32'h20);
        // overflow the victim cache so old lines survive only in L2
        for (int i = 0; i < 14; i++)
            send_request(32'h2000 + (i << (OFS + S1B)), 32'h30 + i);
        send_request(32'h2000, 32'h50);
        drain();

        // Register extremes, every register written.
        write_reg(CFG_L1_HIT_LAT, 10'd255);
        write_reg(CFG_VICTIM_HIT_LAT, 10'd0);
        write_reg(CFG_L2_HIT_LAT, 10'd255);
        write_reg(CFG_L1_L2_XFER, 10'd255);
        write_reg(CFG_MEM_LAT, 10'd1023);

        clock_now = 32'h100;
        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 1)
                hold_req = 1;       // long hold-off: block fills and stalls input
            if (phase == 3)
                quiet = 1;
            for (int n = 0; n < 400; n++) begin
                clock_now += $urandom_range(0, 3);
                // occasional stamp jump exercises unsigned-compare wrap cases
                if ($urandom_range(0, 49) == 0)
                    clock_now = $urandom();
                send_request(pick_address(phase == 2 ? 63 : 15), clock_now);
            end
            drain();
            write_reg(CFG_L1_HIT_LAT, 10'($urandom_range(0, 255)));
            write_reg(CFG_VICTIM_HIT_LAT, 10'($urandom_range(0, 255)));
            write_reg(CFG_L2_HIT_LAT, phase[0] ? 10'd0 : 10'($urandom_range(0, 255)));
            write_reg(CFG_L1_L2_XFER, phase[0] ? 10'd0 : 10'($urandom_range(0, 255)));
            write_reg(CFG_MEM_LAT, phase[0] ? 10'd0 : 10'($urandom_range(0, 1023)));
        end
        drain();

        $display("Ran %0d requests: %0d L1, %0d victim, %0d L2, %0d memory results",
                 sent, n_level[0], n_level[1], n_level[2], n_level[3]);
        $display("Checked %0d results across five register settings", board.checked);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("** l1_victim_l2_cache_lookup: PASSED **");
        else
            $display("** l1_victim_l2_cache_lookup: FAILED **");
        $finish;
    end

    // Watchdog: covers the clearing pass, every stall and the long hold-off.
    initial begin
        #2000000;
        $display("Timeout with %0d results outstanding", board.pending());
        $display("** l1_victim_l2_cache_lookup: FAILED **");
        $finish;
    end
endmodule
